>>> rtl/core/dcs_pkg.sv
// Shared types, constants and saturation helpers of the distance constraint solver.
package dcs_pkg;

  localparam int unsigned POS_W    = 32;  // position and difference width
  localparam int unsigned RAD_W    = 31;  // radius and rest distance width
  localparam int unsigned WGT_W    = 25;  // inverse weight width
  localparam int unsigned WSUM_W   = 26;  // sum of two inverse weights
  localparam int unsigned ROOT_W   = 32;  // distance width, one root bit per step
  localparam int unsigned ERR_W    = 33;  // distance error magnitude width
  localparam int unsigned PROD_W   = 64;  // |component| * |error|
  localparam int unsigned SHARE_W  = 58;  // share * inverse weight
  localparam int unsigned EXT_W    = 35;  // guard width for final position sums

  // Request codes.
  localparam logic REQ_COLLISION = 1'b0;
  localparam logic REQ_JOINT     = 1'b1;

  // Everything that travels with one transaction along the pipeline.
  typedef struct packed {
    logic                req;
    logic [POS_W-1:0]    a_x;
    logic [POS_W-1:0]    a_y;
    logic [POS_W-1:0]    b_x;
    logic [POS_W-1:0]    b_y;
    logic [POS_W-1:0]    dx;
    logic [POS_W-1:0]    dy;
    logic [POS_W-1:0]    radii;
    logic [POS_W-1:0]    target;
    logic [WGT_W-1:0]    wa;
    logic [WGT_W-1:0]    wb;
    logic [WSUM_W-1:0]   wsum;
    logic [ROOT_W-1:0]   span;
    logic [ERR_W-1:0]    err_mag;
    logic                neg_x;
    logic                neg_y;
    logic                contact;
    logic                special;
  } item_t;

  // Clamp a guarded signed sum to 32-bit signed.
  function automatic logic [POS_W-1:0] sat_pos(input logic [EXT_W-1:0] v);
    logic [POS_W-1:0] r;
    if (!v[EXT_W-1] && (|v[EXT_W-2:POS_W-1])) begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end else if (v[EXT_W-1] && !(&v[EXT_W-2:POS_W-1])) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // Sign-extend a 32-bit value to the guard width.
  function automatic logic [EXT_W-1:0] sext_pos(input logic [POS_W-1:0] v);
    return {{(EXT_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  // Magnitude of a 32-bit signed value.
  function automatic logic [POS_W-1:0] mag_pos(input logic [POS_W-1:0] v);
    return v[POS_W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

>>> rtl/core/dcs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, lanes share one divisor.
module dcs_div_pipe #(
  parameter int unsigned NL = 2,   // lanes
  parameter int unsigned NW = 64,  // dividend width
  parameter int unsigned DW = 32,  // divisor width
  parameter int unsigned QW = 33,  // quotient width, one stage per bit
  parameter int unsigned SW = 8    // sideband width
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [NL-1:0][NW-1:0]  num_i,
  input  logic [DW-1:0]          den_i,
  input  logic [SW-1:0]          side_i,
  output logic                   valid_o,
  output logic [NL-1:0][QW-1:0]  quot_o,
  output logic [SW-1:0]          side_o
);

  localparam int unsigned ZW = DW - (NW - QW);

  logic [NL-1:0][DW-1:0] rem_q  [QW];
  logic [NL-1:0][QW-1:0] low_q  [QW];
  logic [DW-1:0]         den_q  [QW];
  logic [SW-1:0]         side_q [QW];
  logic [QW-1:0]         vld_q;

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [NL-1:0][DW-1:0] rin;
    logic [NL-1:0][QW-1:0] lin;
    logic [DW-1:0]         den;
    logic [SW-1:0]         side;
    logic                  vin;
    logic [NL-1:0][DW-1:0] rem_d;
    logic [NL-1:0][QW-1:0] low_d;

    if (s == 0) begin : g_first
      for (genvar l = 0; l < NL; l++) begin : g_lane
        assign rin[l] = {{ZW{1'b0}}, num_i[l][NW-1:QW]};
        assign lin[l] = num_i[l][QW-1:0];
      end
      assign den  = den_i;
      assign side = side_i;
      assign vin  = valid_i;
    end else begin : g_next
      assign rin  = rem_q[s-1];
      assign lin  = low_q[s-1];
      assign den  = den_q[s-1];
      assign side = side_q[s-1];
      assign vin  = vld_q[s-1];
    end

    // Bring in the next dividend bit, subtract where it fits.
    always_comb begin
      logic [DW:0] trial;
      for (int l = 0; l < NL; l++) begin
        trial = {rin[l], lin[l][QW-1]};
        if (trial >= {1'b0, den}) begin
          rem_d[l] = DW'(trial - {1'b0, den});
          low_d[l] = {lin[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[DW-1:0];
          low_d[l] = {lin[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        low_q[s]  <= low_d;
        den_q[s]  <= den;
        side_q[s] <= side;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = low_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

>>> rtl/core/distance_constraint_solver_core.sv
// Distance constraint projection of two 2-D points, fully pipelined.
// Throughput: one transaction per cycle while the output is not stalled; the 32 square
// root stages and the two 33-stage dividers each retire one transaction per cycle.
// A stall on a valid output holds the whole pipeline; bubbles travel as invalid stages.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data is not reset.
module distance_constraint_solver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] a_x_i,
  input  logic [31:0] a_y_i,
  input  logic [31:0] b_x_i,
  input  logic [31:0] b_y_i,
  input  logic [30:0] a_radius_i,
  input  logic [30:0] b_radius_i,
  input  logic [24:0] a_inv_weight_i,
  input  logic [24:0] b_inv_weight_i,
  input  logic [30:0] rest_distance_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] new_a_x_o,
  output logic [31:0] new_a_y_o,
  output logic [31:0] new_b_x_o,
  output logic [31:0] new_b_y_o,
  output logic        corrected_o
);

  localparam int unsigned ItemW = $bits(dcs_pkg::item_t);
  localparam int unsigned RootW = dcs_pkg::ROOT_W;

  // Advance everything unless the finished result is held by the consumer.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Stage 1: saturated difference vector, target and weight sum.
  // ---------------------------------------------------------------------------
  dcs_pkg::item_t s1_d, s1_q;
  logic           s1_vld_q;

  always_comb begin
    s1_d         = '0;
    s1_d.req     = req_type_i;
    s1_d.a_x     = a_x_i;
    s1_d.a_y     = a_y_i;
    s1_d.b_x     = b_x_i;
    s1_d.b_y     = b_y_i;
    s1_d.dx      = dcs_pkg::sat_pos(dcs_pkg::sext_pos(a_x_i) - dcs_pkg::sext_pos(b_x_i));
    s1_d.dy      = dcs_pkg::sat_pos(dcs_pkg::sext_pos(a_y_i) - dcs_pkg::sext_pos(b_y_i));
    s1_d.radii   = {1'b0, a_radius_i} + {1'b0, b_radius_i};
    s1_d.target  = (req_type_i == dcs_pkg::REQ_JOINT) ? {1'b0, rest_distance_i} : s1_d.radii;
    s1_d.wa      = a_inv_weight_i;
    s1_d.wb      = b_inv_weight_i;
    s1_d.wsum    = {1'b0, a_inv_weight_i} + {1'b0, b_inv_weight_i};
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares of the component magnitudes.
  // ---------------------------------------------------------------------------
  dcs_pkg::item_t s2_q;
  logic           s2_vld_q;
  logic [63:0]    sq_x_q, sq_y_q;
  logic [31:0]    mag_dx1, mag_dy1;
  assign mag_dx1 = dcs_pkg::mag_pos(s1_q.dx);
  assign mag_dy1 = dcs_pkg::mag_pos(s1_q.dy);

  // ---------------------------------------------------------------------------
  // Stage 3: squared length.
  // ---------------------------------------------------------------------------
  dcs_pkg::item_t s3_q;
  logic           s3_vld_q;
  logic [63:0]    sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q   <= s1_d;
      s2_q   <= s1_q;
      sq_x_q <= 64'(mag_dx1) * 64'(mag_dx1);
      sq_y_q <= 64'(mag_dy1) * 64'(mag_dy1);
      s3_q   <= s2_q;
      sum_q  <= sq_x_q + sq_y_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root: one root bit per stage, most significant first.
  // ---------------------------------------------------------------------------
  logic [32:0]      sq_rem_q  [RootW];
  logic [RootW-1:0] sq_root_q [RootW];
  logic [63:0]      sq_v_q    [RootW];
  dcs_pkg::item_t   sq_item_q [RootW];
  logic [RootW-1:0] sq_vld_q;

  for (genvar s = 0; s < RootW; s++) begin : g_sqrt
    localparam int unsigned Bit = RootW - 1 - s;
    logic [32:0]      rem_in;
    logic [RootW-1:0] root_in;
    logic [63:0]      v_in;
    dcs_pkg::item_t   item_in;
    logic             vld_in;
    logic [34:0]      rem_sh;
    logic [34:0]      trial;
    logic [32:0]      rem_d;
    logic [RootW-1:0] root_d;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = sum_q;
      assign item_in = s3_q;
      assign vld_in  = s3_vld_q;
    end else begin : g_next
      assign rem_in  = sq_rem_q[s-1];
      assign root_in = sq_root_q[s-1];
      assign v_in    = sq_v_q[s-1];
      assign item_in = sq_item_q[s-1];
      assign vld_in  = sq_vld_q[s-1];
    end

    assign rem_sh = {rem_in, v_in[2*Bit+1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_d  = 33'(rem_sh - trial);
        root_d = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh[32:0];
        root_d = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s] <= 1'b0;
      end else if (en) begin
        sq_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[s]  <= rem_d;
        sq_root_q[s] <= root_d;
        sq_v_q[s]    <= v_in;
        sq_item_q[s] <= item_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Error stage: distance error, contact test, degenerate case, move signs.
  // ---------------------------------------------------------------------------
  dcs_pkg::item_t e_d, e_q;
  logic           e_vld_q;
  logic [33:0]    err;

  always_comb begin
    e_d         = sq_item_q[RootW-1];
    e_d.span    = sq_root_q[RootW-1];
    err         = {2'b00, e_d.span} - {2'b00, e_d.target};
    e_d.err_mag = err[33] ? 33'(~err + 1'b1) : err[32:0];
    e_d.contact = (e_d.req == dcs_pkg::REQ_JOINT) || (e_d.span < e_d.radii);
    e_d.special = (e_d.span == '0) || (e_d.wsum == '0);
    e_d.neg_x   = e_d.dx[31] ^ err[33];
    e_d.neg_y   = e_d.dy[31] ^ err[33];
  end

  // ---------------------------------------------------------------------------
  // First product stage: |component| * |error|.
  // ---------------------------------------------------------------------------
  dcs_pkg::item_t m1_q;
  logic           m1_vld_q;
  logic [1:0][dcs_pkg::PROD_W-1:0] m1_num_q;
  logic [31:0]    mag_dx2, mag_dy2;
  assign mag_dx2 = dcs_pkg::mag_pos(e_q.dx);
  assign mag_dy2 = dcs_pkg::mag_pos(e_q.dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q  <= 1'b0;
      m1_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q  <= sq_vld_q[RootW-1];
      m1_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q         <= e_d;
      m1_q        <= e_q;
      m1_num_q[0] <= dcs_pkg::PROD_W'(mag_dx2) * dcs_pkg::PROD_W'(e_q.err_mag);
      m1_num_q[1] <= dcs_pkg::PROD_W'(mag_dy2) * dcs_pkg::PROD_W'(e_q.err_mag);
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by the distance: per-component share of the error.
  // ---------------------------------------------------------------------------
  logic                              da_vld;
  logic [1:0][dcs_pkg::ERR_W-1:0]    da_quot;
  logic [ItemW-1:0]                  da_side;
  dcs_pkg::item_t                    da_item;

  dcs_div_pipe #(
    .NL (2),
    .NW (dcs_pkg::PROD_W),
    .DW (dcs_pkg::ROOT_W),
    .QW (dcs_pkg::ERR_W),
    .SW (ItemW)
  ) u_div_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m1_vld_q),
    .num_i   (m1_num_q),
    .den_i   (m1_q.span),
    .side_i  (m1_q),
    .valid_o (da_vld),
    .quot_o  (da_quot),
    .side_o  (da_side)
  );

  assign da_item = dcs_pkg::item_t'(da_side);

  // ---------------------------------------------------------------------------
  // Second product stage: share * inverse weight of each point.
  // Lane order: A x, B x, A y, B y.
  // ---------------------------------------------------------------------------
  dcs_pkg::item_t m2_q;
  logic           m2_vld_q;
  logic [3:0][dcs_pkg::SHARE_W-1:0] m2_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= da_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_q        <= da_item;
      m2_num_q[0] <= dcs_pkg::SHARE_W'(da_quot[0]) * dcs_pkg::SHARE_W'(da_item.wa);
      m2_num_q[1] <= dcs_pkg::SHARE_W'(da_quot[0]) * dcs_pkg::SHARE_W'(da_item.wb);
      m2_num_q[2] <= dcs_pkg::SHARE_W'(da_quot[1]) * dcs_pkg::SHARE_W'(da_item.wa);
      m2_num_q[3] <= dcs_pkg::SHARE_W'(da_quot[1]) * dcs_pkg::SHARE_W'(da_item.wb);
    end
  end

  // ---------------------------------------------------------------------------
  // Divide by the weight sum: move of each point.
  // ---------------------------------------------------------------------------
  logic                              db_vld;
  logic [3:0][dcs_pkg::ERR_W-1:0]    db_quot;
  logic [ItemW-1:0]                  db_side;
  dcs_pkg::item_t                    db_item;

  dcs_div_pipe #(
    .NL (4),
    .NW (dcs_pkg::SHARE_W),
    .DW (dcs_pkg::WSUM_W),
    .QW (dcs_pkg::ERR_W),
    .SW (ItemW)
  ) u_div_wsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m2_vld_q),
    .num_i   (m2_num_q),
    .den_i   (m2_q.wsum),
    .side_i  (m2_q),
    .valid_o (db_vld),
    .quot_o  (db_quot),
    .side_o  (db_side)
  );

  assign db_item = dcs_pkg::item_t'(db_side);

  // ---------------------------------------------------------------------------
  // Final stage: apply the moves, or the halved fallback, or pass through.
  // ---------------------------------------------------------------------------
  logic [31:0] na_x_d, na_y_d, nb_x_d, nb_y_d;
  logic [31:0] na_x_q, na_y_q, nb_x_q, nb_y_q;
  logic        corr_d, corr_q;

  always_comb begin
    logic [dcs_pkg::EXT_W-1:0] ax, ay, bx, by;
    logic [dcs_pkg::EXT_W-1:0] hx, hy, dy_e;
    logic [dcs_pkg::EXT_W-1:0] uax, ubx, uay, uby;
    logic [dcs_pkg::EXT_W-1:0] max_m, mbx_m, may_m, mby_m;
    ax    = dcs_pkg::sext_pos(db_item.a_x);
    ay    = dcs_pkg::sext_pos(db_item.a_y);
    bx    = dcs_pkg::sext_pos(db_item.b_x);
    by    = dcs_pkg::sext_pos(db_item.b_y);
    // Halve with rounding toward zero: bias negatives by one before the shift.
    hx    = {3'b000, 1'b0, db_item.target[31:1]};
    dy_e  = dcs_pkg::sext_pos(db_item.dy);
    hy    = $signed(dy_e + {{(dcs_pkg::EXT_W-1){1'b0}}, db_item.dy[31]}) >>> 1;
    uax   = {2'b00, db_quot[0]};
    ubx   = {2'b00, db_quot[1]};
    uay   = {2'b00, db_quot[2]};
    uby   = {2'b00, db_quot[3]};
    max_m = db_item.neg_x ? (~uax + 1'b1) : uax;
    mbx_m = db_item.neg_x ? (~ubx + 1'b1) : ubx;
    may_m = db_item.neg_y ? (~uay + 1'b1) : uay;
    mby_m = db_item.neg_y ? (~uby + 1'b1) : uby;

    na_x_d = db_item.a_x;
    na_y_d = db_item.a_y;
    nb_x_d = db_item.b_x;
    nb_y_d = db_item.b_y;
    corr_d = 1'b0;
    if (db_item.contact) begin
      corr_d = 1'b1;
      if (db_item.special) begin
        na_x_d = dcs_pkg::sat_pos(ax - hx);
        na_y_d = dcs_pkg::sat_pos(ay - hy);
        nb_x_d = dcs_pkg::sat_pos(bx + hx);
        nb_y_d = dcs_pkg::sat_pos(by + hy);
      end else begin
        na_x_d = dcs_pkg::sat_pos(ax - max_m);
        na_y_d = dcs_pkg::sat_pos(ay - may_m);
        nb_x_d = dcs_pkg::sat_pos(bx + mbx_m);
        nb_y_d = dcs_pkg::sat_pos(by + mby_m);
      end
    end
  end

  // Output register: hold while the consumer stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= db_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na_x_q <= na_x_d;
      na_y_q <= na_y_d;
      nb_x_q <= nb_x_d;
      nb_y_q <= nb_y_d;
      corr_q <= corr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_a_x_o   = na_x_q;
  assign new_a_y_o   = na_y_q;
  assign new_b_x_o   = nb_x_q;
  assign new_b_y_o   = nb_y_q;
  assign corrected_o = corr_q;

endmodule

>>> dv/distance_constraint_solver_core_tb.sv
// Self-checking testbench for the distance constraint solver core.
module distance_constraint_solver_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned PIPE_DEPTH   = 105;   // pipeline depth of the core
  localparam int unsigned IDLE_LIMIT   = 4000;  // cycles without any transaction
  localparam logic [31:0] POS_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_MIN      = 32'h8000_0000;
  localparam logic [24:0] WGT_MAX      = 25'h100_0000;
  localparam logic [30:0] RAD_MAX      = 31'h7FFF_FFFF;

  // One request as driven on the input ports.
  typedef struct packed {
    logic        req;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [30:0] a_rad;
    logic [30:0] b_rad;
    logic [24:0] a_w;
    logic [24:0] b_w;
    logic [30:0] rest;
  } pair_req_t;

  // One corrected point pair as seen on the output ports.
  typedef struct packed {
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic        corrected;
  } pair_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [31:0] a_x_i, a_y_i, b_x_i, b_y_i;
  logic [30:0] a_radius_i, b_radius_i, rest_distance_i;
  logic [24:0] a_inv_weight_i, b_inv_weight_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] new_a_x_o, new_a_y_o, new_b_x_o, new_b_y_o;
  logic        corrected_o;

  distance_constraint_solver_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .a_x_i           (a_x_i),
    .a_y_i           (a_y_i),
    .b_x_i           (b_x_i),
    .b_y_i           (b_y_i),
    .a_radius_i      (a_radius_i),
    .b_radius_i      (b_radius_i),
    .a_inv_weight_i  (a_inv_weight_i),
    .b_inv_weight_i  (b_inv_weight_i),
    .rest_distance_i (rest_distance_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .new_a_x_o       (new_a_x_o),
    .new_a_y_o       (new_a_y_o),
    .new_b_x_o       (new_b_x_o),
    .new_b_y_o       (new_b_y_o),
    .corrected_o     (corrected_o)
  );

  pair_res_t   pending_pairs[$];   // corrected pairs still owed by the core
  pair_req_t   dir_reqs[$];        // directed table: stimulus
  pair_res_t   dir_results[$];     // directed table: typed-in result
  bit          dir_typed[$];       // directed table: result typed in rather than predicted
  int unsigned errors;
  int unsigned sent;
  int unsigned total;
  bit          sending_done;
  bit          in_fire;
  bit          out_fire;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Integer square root, rounded down, one result bit per pass.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Move of one point along one component: its weight's share of the scaled error.
  function automatic longint weighted_move(longint c, longint err, longint unsigned span,
                                           longint unsigned w, longint unsigned wsum);
    longint unsigned stretch;
    longint unsigned part;
    stretch = (magnitude(c) * magnitude(err)) / span;
    part    = (stretch * w) / wsum;
    return ((c < 0) != (err < 0)) ? -longint'(part) : longint'(part);
  endfunction

  function automatic longint half_to_zero(longint v);
    return (v < 0) ? -longint'(magnitude(v) >> 1) : longint'(magnitude(v) >> 1);
  endfunction

  function automatic pair_res_t project_pair(pair_req_t s);
    pair_res_t       r;
    longint          ax, ay, bx, by, dx, dy, err, mx, my;
    longint unsigned span, radii, target, wsum;
    ax = longint'($signed(s.a_x));
    ay = longint'($signed(s.a_y));
    bx = longint'($signed(s.b_x));
    by = longint'($signed(s.b_y));
    dx = clamp32(ax - bx);
    dy = clamp32(ay - by);
    span   = floor_root(magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy));
    radii  = longint'(s.a_rad) + longint'(s.b_rad);
    target = (s.req == dcs_pkg::REQ_JOINT) ? longint'(s.rest) : radii;
    wsum   = longint'(s.a_w) + longint'(s.b_w);
    r = '{a_x: s.a_x, a_y: s.a_y, b_x: s.b_x, b_y: s.b_y, corrected: 1'b0};
    if (s.req == dcs_pkg::REQ_JOINT || span < radii) begin
      r.corrected = 1'b1;
      if (span == 0 || wsum == 0) begin
        // degenerate: x takes the target, both points move half each way
        mx = half_to_zero(longint'(target));
        my = half_to_zero(dy);
        r.a_x = 32'(clamp32(ax - mx));
        r.a_y = 32'(clamp32(ay - my));
        r.b_x = 32'(clamp32(bx + mx));
        r.b_y = 32'(clamp32(by + my));
      end else begin
        err = longint'(span) - longint'(target);
        r.a_x = 32'(clamp32(ax - weighted_move(dx, err, span, s.a_w, wsum)));
        r.a_y = 32'(clamp32(ay - weighted_move(dy, err, span, s.a_w, wsum)));
        r.b_x = 32'(clamp32(bx + weighted_move(dx, err, span, s.b_w, wsum)));
        r.b_y = 32'(clamp32(by + weighted_move(dy, err, span, s.b_w, wsum)));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic pair_req_t pair_of(logic req, logic [31:0] ax, logic [31:0] ay,
                                        logic [31:0] bx, logic [31:0] by,
                                        logic [30:0] ra, logic [30:0] rb,
                                        logic [24:0] wa, logic [24:0] wb,
                                        logic [30:0] rest);
    return '{req: req, a_x: ax, a_y: ay, b_x: bx, b_y: by, a_rad: ra, b_rad: rb,
             a_w: wa, b_w: wb, rest: rest};
  endfunction

  // Add a directed row; typed rows carry their own result, others use the predictor.
  function automatic void add_row(pair_req_t s, bit typed, pair_res_t r);
    dir_reqs.insert(dir_reqs.size(), s);
    dir_typed.insert(dir_typed.size(), typed);
    dir_results.insert(dir_results.size(), r);
  endfunction

  function automatic void build_table();
    pair_res_t none;
    none = '0;
    // far apart: no contact, nothing moves
    add_row(pair_of(dcs_pkg::REQ_COLLISION, 0, 0, 32'd100 << 16, 0, 31'd1 << 16, 31'd1 << 16,
                    25'd1 << 16, 25'd1 << 16, 31'd9 << 16), 1,
            '{a_x: 0, a_y: 0, b_x: 32'd100 << 16, b_y: 0, corrected: 1'b0});
    // exactly touching (3-4-5): still no contact
    add_row(pair_of(dcs_pkg::REQ_COLLISION, 32'd3 << 16, 32'd4 << 16, 0, 0,
                    31'h28000, 31'h28000, 25'd1 << 16, 25'd1 << 16, 0), 1,
            '{a_x: 32'd3 << 16, a_y: 32'd4 << 16, b_x: 0, b_y: 0, corrected: 1'b0});
    // coincident joint: x takes the rest distance
    add_row(pair_of(dcs_pkg::REQ_JOINT, 5, 7, 5, 7, RAD_MAX, RAD_MAX, 25'd3, 25'd9, 31'd6), 1,
            '{a_x: 2, a_y: 7, b_x: 8, b_y: 7, corrected: 1'b1});
    // both immovable joint
    add_row(pair_of(dcs_pkg::REQ_JOINT, 10, 3, 0, 0, 0, 0, 0, 0, 31'd4), 1,
            '{a_x: 8, a_y: 2, b_x: 2, b_y: 1, corrected: 1'b1});
    // coincident collision with a tiny radius: contact, but half of one rounds to nothing
    add_row(pair_of(dcs_pkg::REQ_COLLISION, 32'hFFFF_FFF0, 9, 32'hFFFF_FFF0, 9, 31'd1, 0,
                    WGT_MAX, WGT_MAX, RAD_MAX), 1,
            '{a_x: 32'hFFFF_FFF0, a_y: 9, b_x: 32'hFFFF_FFF0, b_y: 9, corrected: 1'b1});
    // coincident at the corner with the largest rest distance: B saturates
    add_row(pair_of(dcs_pkg::REQ_JOINT, POS_MAX, POS_MIN, POS_MAX, POS_MIN, 0, 0,
                    25'd1, 0, RAD_MAX), 1,
            '{a_x: 32'h4000_0000, a_y: POS_MIN, b_x: POS_MAX, b_y: POS_MIN, corrected: 1'b1});
    // predicted rows: extremes, saturation, unused fields, one-sided weights
    add_row(pair_of(dcs_pkg::REQ_JOINT, POS_MAX, POS_MAX, POS_MIN, POS_MIN, RAD_MAX, RAD_MAX,
                    WGT_MAX, WGT_MAX, 0), 0, none);
    add_row(pair_of(dcs_pkg::REQ_JOINT, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 0, 0,
                    WGT_MAX, 25'd1, RAD_MAX), 0, none);
    add_row(pair_of(dcs_pkg::REQ_COLLISION, POS_MAX, 0, POS_MIN, 0, RAD_MAX, RAD_MAX,
                    25'd1 << 16, 0, 0), 0, none);
    add_row(pair_of(dcs_pkg::REQ_COLLISION, 32'hFFFF_0000, 32'hFFFE_0000, 32'h0001_0000, 0,
                    31'd3 << 16, 31'd2 << 16, 0, WGT_MAX, RAD_MAX), 0, none);
    add_row(pair_of(dcs_pkg::REQ_JOINT, 32'd1 << 16, 32'd1 << 16, 0, 0, RAD_MAX, 0,
                    25'd1 << 16, 25'd3 << 16, 31'd10 << 16), 0, none);
    add_row(pair_of(dcs_pkg::REQ_JOINT, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, RAD_MAX,
                    25'h1FF_FFFF & WGT_MAX, 25'h0AA_AAAA, 31'h5555_5555), 0, none);
    add_row(pair_of(dcs_pkg::REQ_COLLISION, 32'h8000_0001, 32'h7FFF_FFFE, 32'h8000_0000,
                    32'h7FFF_FFFF, 31'h0155_5555, 31'h002A_AAAA,
                    25'h0FF_FFFF, 25'h055_5555, RAD_MAX), 0, none);
    add_row(pair_of(dcs_pkg::REQ_JOINT, 32'h1234_5678, 32'hEDCB_A987, 32'h1234_0000,
                    32'hEDCB_0000, 0, 0, 25'd1, WGT_MAX, 31'd1), 0, none);
  endfunction

  // Random pair: mostly near neighbours that really touch, some full-range noise.
  function automatic pair_req_t random_pair();
    pair_req_t s;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    s.req   = 1'($urandom_range(0, 1));
    s.a_x   = $urandom;
    s.a_y   = $urandom;
    s.a_rad = 31'($urandom);
    s.b_rad = 31'($urandom);
    s.rest  = 31'($urandom);
    s.a_w   = 25'($urandom_range(0, 32'h100_0000));
    s.b_w   = 25'($urandom_range(0, 32'h100_0000));
    if (mode < 2) begin
      s.b_x = $urandom;
      s.b_y = $urandom;
    end else begin
      s.b_x   = 32'(s.a_x + $urandom_range(0, 400000) - 200000);
      s.b_y   = 32'(s.a_y + $urandom_range(0, 400000) - 200000);
      s.a_rad = 31'($urandom_range(0, 250000));
      s.b_rad = 31'($urandom_range(0, 250000));
      s.rest  = 31'($urandom_range(0, 500000));
      if (mode == 9) s.b_x = s.a_x;
    end
    if ($urandom_range(0, 9) == 0) s.a_w = 0;
    if ($urandom_range(0, 9) == 0) s.b_w = 0;
    return s;
  endfunction

  // Mostly short gaps, now and then a long one; none inside the quiet window.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: hold a stalled transaction, advance on acceptance
  // ---------------------------------------------------------------------------

  initial begin
    pair_req_t   cur;
    pair_res_t   cur_res;
    bit          cur_typed;
    int unsigned next;
    int unsigned gap;
    in_valid_i      <= 1'b0;
    req_type_i      <= dcs_pkg::REQ_COLLISION;
    a_x_i           <= '0;
    a_y_i           <= '0;
    b_x_i           <= '0;
    b_y_i           <= '0;
    a_radius_i      <= '0;
    b_radius_i      <= '0;
    a_inv_weight_i  <= '0;
    b_inv_weight_i  <= '0;
    rest_distance_i <= '0;
    errors       = 0;
    sent         = 0;
    sending_done = 1'b0;
    next         = 0;
    gap          = 0;
    build_table();
    total = dir_reqs.size() + RANDOM_ITEMS;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        // log what the core owes for this transaction
        pending_pairs.insert(pending_pairs.size(), cur_typed ? cur_res : project_pair(cur));
        sent++;
        if (sent == total) sending_done = 1'b1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap > 0 || next == total) begin
          if (gap > 0) gap--;
          in_valid_i <= 1'b0;
        end else begin
          if (next < dir_reqs.size()) begin
            cur       = dir_reqs[next];
            cur_typed = dir_typed[next];
            cur_res   = dir_results[next];
          end else begin
            cur       = random_pair();
            cur_typed = 1'b0;
          end
          next++;
          gap = pick_gap(next > 400 && next < 600);
          in_valid_i      <= 1'b1;
          req_type_i      <= cur.req;
          a_x_i           <= cur.a_x;
          a_y_i           <= cur.a_y;
          b_x_i           <= cur.b_x;
          b_y_i           <= cur.b_y;
          a_radius_i      <= cur.a_rad;
          b_radius_i      <= cur.b_rad;
          a_inv_weight_i  <= cur.a_w;
          b_inv_weight_i  <= cur.b_w;
          rest_distance_i <= cur.rest;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, then compare against the oldest owed pair
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        hold = pick_gap(sent > 400 && sent < 600);
        out_stall_i <= (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk_i) begin
    pair_res_t want;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    if (out_fire) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected transaction from the core");
        errors++;
      end else begin
        want = pending_pairs.pop_front();
        if (new_a_x_o !== want.a_x) begin
          $error("new_a_x expected %h actual %h", want.a_x, new_a_x_o);
          errors++;
        end
        if (new_a_y_o !== want.a_y) begin
          $error("new_a_y expected %h actual %h", want.a_y, new_a_y_o);
          errors++;
        end
        if (new_b_x_o !== want.b_x) begin
          $error("new_b_x expected %h actual %h", want.b_x, new_b_x_o);
          errors++;
        end
        if (new_b_y_o !== want.b_y) begin
          $error("new_b_y expected %h actual %h", want.b_y, new_b_y_o);
          errors++;
        end
        if (corrected_o !== want.corrected) begin
          $error("corrected expected %b actual %b", want.corrected, corrected_o);
          errors++;
        end
      end
    end
  end

  // Drop the run if the core stops moving transactions for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      #1;
      idle = (in_fire || out_fire) ? 0 : idle + 1;
      if (idle >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Reset once, then wait for every owed pair and a drain window.
  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sending_done && pending_pairs.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
